@@ design/bitmap_frame_allocator_assert.svh @@
// assertion macros for the bitmap frame allocator checker
// expects signals named clk and rst_n in the scope where a macro is used
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// checked only outside reset
`define BFA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BFA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/bfa_pkg.sv @@
// shared constants and types of the bitmap frame allocator
// no dependencies
package bfa_pkg;

  localparam int POOL_WORDS_DEF = 1024;
  localparam int WORD_BITS      = 64;
  localparam int BIT_W          = 6;
  localparam int FRAME_SHIFT    = 12;
  localparam int FRAME_ADDR_W   = 32;
  localparam int ADDR_W         = 28;
  localparam int STATUS_W       = 2;
  localparam int COUNT_W        = 17;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NONE   = 2'd1,
    ST_RANGE  = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  typedef struct packed {
    logic             any_zero;
    logic [BIT_W-1:0] idx;
  } ffz_res_t;

endpackage

@@ design/bfa_if.sv @@
// request and response channels of the bitmap frame allocator
// depends on bfa_pkg
interface bfa_req_if;
  logic                             valid;
  logic                             ready;
  logic                             req_type;
  logic [bfa_pkg::FRAME_ADDR_W-1:0] frame_address;

  modport source (output valid, output req_type, output frame_address, input ready);
  modport sink (input valid, input req_type, input frame_address, output ready);
endinterface

interface bfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bfa_pkg::ADDR_W-1:0]   alloc_address;
  logic [bfa_pkg::STATUS_W-1:0] status;
  logic [bfa_pkg::COUNT_W-1:0]  free_count;

  modport source (output valid, output alloc_address, output status, output free_count,
                  input ready);
  modport sink (input valid, input alloc_address, input status, input free_count,
                output ready);
endinterface

@@ design/bitmap_frame_allocator.sv @@
// top level of the bitmap page frame allocator
// depends on bfa_pkg, bfa_if, bfa_ram and bfa_ffz
//
// Keeps one used/free bit per 4 KiB frame in a POOL_WORDS x 64 bit ram plus
// an exact free-frame count. An allocate transaction returns the byte address
// of the lowest free frame and marks it used; a free transaction clears the
// frame holding frame_address. Status 0 ok, 1 none free, 2 address beyond the
// bitmap, 3 frame already free. After reset the block sweeps the ram to all
// ones (every frame used), one word a cycle, so in_ch.ready stays low until
// the sweep ends. Items are handled one at a time. A free passes through the
// read, check and done states, or goes straight to done when its address
// lies beyond the bitmap; an allocate with none free goes straight to done.
// An allocate that succeeds reads ram words one by one, each word passing
// a read state and a check state through the shared find-first-zero unit.
// The scan starts at a low-water hint below which every word is known full,
// so the first word read usually holds a free frame. The result sits in an
// output register, so the next item may be accepted while it waits to be taken.
module bitmap_frame_allocator #(
  parameter int POOL_WORDS = bfa_pkg::POOL_WORDS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  bfa_req_if.sink    in_ch,
  bfa_rsp_if.source  out_ch
);
  localparam int AW     = (POOL_WORDS > 1) ? $clog2(POOL_WORDS) : 1;
  localparam int TOTAL  = POOL_WORDS * bfa_pkg::WORD_BITS;
  localparam int CNT_W  = $clog2(TOTAL + 1);
  localparam int WB     = bfa_pkg::WORD_BITS;
  localparam int BW     = bfa_pkg::BIT_W;
  localparam logic [31:0]   TOTAL_U   = 32'(TOTAL);
  localparam logic [AW-1:0] LAST_WORD = AW'(POOL_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 addr_r, addr_nxt;     // word under work, or sweep pointer
  logic [AW-1:0]                 hint_r, hint_nxt;     // every word below is full
  logic [BW-1:0]                 bit_r, bit_nxt;
  logic                          req_r, req_nxt;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  bfa_pkg::status_t              res_st_r, res_st_nxt;
  logic [bfa_pkg::ADDR_W-1:0]    res_addr_r, res_addr_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [bfa_pkg::ADDR_W-1:0]    out_addr_r, out_addr_nxt;
  logic [bfa_pkg::STATUS_W-1:0]  out_st_r, out_st_nxt;
  logic [bfa_pkg::COUNT_W-1:0]   out_cnt_r, out_cnt_nxt;

  logic                          ram_we;
  logic [WB-1:0]                 ram_wdata;
  logic [WB-1:0]                 ram_rdata;
  logic                          chk_we;
  logic [WB-1:0]                 chk_wdata;
  bfa_pkg::ffz_res_t             ffz_res;

  logic [31:0]                   frame_ext;
  logic [31:0]                   frame_fx;
  logic [31:0]                   byte_fx;
  logic [31:0]                   cnt_fx;
  logic [WB-1:0]                 bit_mask;

  bfa_ram #(
    .WIDTH (WB),
    .DEPTH (POOL_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (state_r == S_READ),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // shared unit, consulted once per word during an allocate scan
  bfa_ffz u_ffz (
    .word (ram_rdata),
    .res  (ffz_res)
  );

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.alloc_address = out_addr_r;
  assign out_ch.status        = out_st_r;
  assign out_ch.free_count    = out_cnt_r;

  // frame number of the incoming address, offset within the frame dropped
  assign frame_ext = in_ch.frame_address >> bfa_pkg::FRAME_SHIFT;
  // byte address of the frame found by the scan
  assign frame_fx  = (32'(addr_r) << BW) | 32'(ffz_res.idx);
  assign byte_fx   = frame_fx << bfa_pkg::FRAME_SHIFT;
  assign cnt_fx    = 32'(cnt_r);
  assign bit_mask  = WB'(1) << bit_r;

  assign ram_we    = (state_r == S_CLEAR) || chk_we;
  assign ram_wdata = (state_r == S_CLEAR) ? '1 : chk_wdata;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    hint_nxt      = hint_r;
    bit_nxt       = bit_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    res_st_nxt    = res_st_r;
    res_addr_nxt  = res_addr_r;
    out_valid_nxt = out_valid_r;
    out_addr_nxt  = out_addr_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    chk_we        = 1'b0;
    chk_wdata     = ram_rdata;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        // reset sweep, every frame marked used
        addr_nxt = addr_r + AW'(1);
        if (addr_r == LAST_WORD) begin
          addr_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt      = in_ch.req_type;
          res_addr_nxt = '0;
          if (in_ch.req_type == bfa_pkg::REQ_ALLOC) begin
            if (cnt_r == '0) begin
              res_st_nxt = bfa_pkg::ST_NONE;
              state_nxt  = S_DONE;
            end else begin
              addr_nxt  = hint_r;
              state_nxt = S_READ;
            end
          end else begin
            if (frame_ext >= TOTAL_U) begin
              res_st_nxt = bfa_pkg::ST_RANGE;
              state_nxt  = S_DONE;
            end else begin
              addr_nxt  = frame_ext[BW +: AW];
              bit_nxt   = frame_ext[BW-1:0];
              state_nxt = S_READ;
            end
          end
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (req_r == bfa_pkg::REQ_ALLOC) begin
          if (ffz_res.any_zero) begin
            chk_we       = 1'b1;
            chk_wdata    = ram_rdata | (WB'(1) << ffz_res.idx);
            hint_nxt     = addr_r;
            cnt_nxt      = cnt_r - CNT_W'(1);
            res_st_nxt   = bfa_pkg::ST_OK;
            res_addr_nxt = byte_fx[bfa_pkg::ADDR_W-1:0];
            state_nxt    = S_DONE;
          end else begin
            // word full, move on; a free frame is known to lie further up
            addr_nxt  = addr_r + AW'(1);
            state_nxt = S_READ;
          end
        end else begin
          if ((ram_rdata & bit_mask) == '0) begin
            res_st_nxt = bfa_pkg::ST_DOUBLE;
          end else begin
            chk_we     = 1'b1;
            chk_wdata  = ram_rdata & ~bit_mask;
            cnt_nxt    = cnt_r + CNT_W'(1);
            res_st_nxt = bfa_pkg::ST_OK;
            if (addr_r < hint_r) begin
              hint_nxt = addr_r;
            end
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_addr_r;
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = cnt_fx[bfa_pkg::COUNT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      hint_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    bit_r      <= bit_nxt;
    req_r      <= req_nxt;
    res_st_r   <= res_st_nxt;
    res_addr_r <= res_addr_nxt;
    out_addr_r <= out_addr_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end
endmodule

@@ design/bfa_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module bfa_ram #(
  parameter int   WIDTH = 64,
  parameter int   DEPTH = 1024,
  localparam int  AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [AW-1:0]         waddr,
  input  logic [WIDTH-1:0]      wdata,
  input  logic                  re,
  input  logic [AW-1:0]         raddr,
  output logic [WIDTH-1:0]      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

@@ design/bfa_ffz.sv @@
// find-first-zero unit, lowest clear bit of one bitmap word
// depends on bfa_pkg
module bfa_ffz (
  input  logic [bfa_pkg::WORD_BITS-1:0] word,
  output bfa_pkg::ffz_res_t             res
);
  always_comb begin
    res.any_zero = ~(&word);
    res.idx      = '0;
    // scan downwards so the lowest clear bit wins
    for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (!word[i]) begin
        res.idx = i[bfa_pkg::BIT_W-1:0];
      end
    end
  end
endmodule

@@ design/bfa_checker.sv @@
// port-level checks of the bitmap frame allocator and their bind
// depends on bfa_pkg and bitmap_frame_allocator_assert.svh
`include "bitmap_frame_allocator_assert.svh"

module bfa_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bfa_pkg::ADDR_W-1:0]   out_alloc_address,
  input logic [bfa_pkg::STATUS_W-1:0] out_status,
  input logic [bfa_pkg::COUNT_W-1:0]  out_free_count
);
  `BFA_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BFA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "second transaction taken while busy")
  `BFA_ASSERT(a_err_no_addr, out_valid && out_status != bfa_pkg::ST_OK |-> out_alloc_address == '0, "address given with error status")
  `BFA_ASSERT(a_none_zero_count, out_valid && out_status == bfa_pkg::ST_NONE |-> out_free_count == '0, "none free reported with frames free")
  `BFA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result shown straight after reset")
endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_alloc_address (out_ch.alloc_address),
  .out_status        (out_ch.status),
  .out_free_count    (out_ch.free_count)
);
